// ----- hdl/sha1_pkg.sv -----
// ============================================================================
// SHA-1 engine package
// Shared types, round constants and helper functions of the SHA-1 engine.
// ============================================================================
package sha1_pkg;

  localparam int unsigned BlkWords    = 16;
  localparam int unsigned NumRounds   = 80;
  localparam int unsigned DigestWords = 5;

  typedef logic [31:0] word_t;

  // Round constants, one per group of twenty rounds.
  localparam word_t KRound0 = 32'h5a82_7999;
  localparam word_t KRound1 = 32'h6ed9_eba1;
  localparam word_t KRound2 = 32'h8f1b_bcdc;
  localparam word_t KRound3 = 32'hca62_c1d6;

  // Initial chaining values H0 to H4.
  localparam word_t InitH [DigestWords] = '{
    32'h6745_2301, 32'hefcd_ab89, 32'h98ba_dcfe, 32'h1032_5476, 32'hc3d2_e1f0
  };

  // Padding marker as it appears when it opens a word.
  localparam word_t PadMarker = 32'h8000_0000;

  localparam logic [2:0] FullBytes = 3'd4;
  localparam logic [2:0] LastIdx   = 3'd4;

  // One message word after classification.
  typedef struct packed {
    word_t      word;       // data, already masked and marked on a short last word
    logic [2:0] nbytes;     // bytes that count toward the message length
    logic       last;       // final word of the message
    logic       mark_next;  // a full last word: the marker opens the next word
  } q_entry_t;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } core_state_e;

  typedef struct packed {
    core_state_e state;
    logic [4:0]  fill;
  } core_stat_t;

  // Boolean function of the round group.
  function automatic word_t round_f(input logic [6:0] rnd, input word_t b,
                                    input word_t c, input word_t d);
    word_t f;
    if (rnd < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (rnd < 7'd40) begin
      f = b ^ c ^ d;
    end else if (rnd < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  function automatic word_t round_k(input logic [6:0] rnd);
    word_t k;
    if (rnd < 7'd20) begin
      k = KRound0;
    end else if (rnd < 7'd40) begin
      k = KRound1;
    end else if (rnd < 7'd60) begin
      k = KRound2;
    end else begin
      k = KRound3;
    end
    return k;
  endfunction

endpackage

// ----- hdl/sha1_front.sv -----
// ============================================================================
// SHA-1 input front end
// Takes message beats and classifies them: short last words are masked and
// get the padding marker, the length contribution is settled here.
// ============================================================================
module sha1_front (
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [39:0]       s_axis_tdata,
  input  logic              s_axis_tlast,
  input  logic              q_full_i,
  output logic              push_o,
  output sha1_pkg::q_entry_t entry_o
);
  import sha1_pkg::*;

  logic [2:0] vb_sat;
  word_t      data;

  assign data          = s_axis_tdata[31:0];
  assign s_axis_tready = !q_full_i;
  assign push_o        = s_axis_tvalid && !q_full_i;

  // Counts above four are taken as four.
  assign vb_sat = (s_axis_tdata[34:32] > FullBytes) ? FullBytes : s_axis_tdata[34:32];

  always_comb begin
    entry_o.last      = s_axis_tlast;
    entry_o.nbytes    = FullBytes;
    entry_o.mark_next = 1'b0;
    entry_o.word      = data;
    if (s_axis_tlast) begin
      entry_o.nbytes    = vb_sat;
      entry_o.mark_next = (vb_sat == FullBytes);
      unique case (vb_sat)
        3'd0:    entry_o.word = PadMarker;
        3'd1:    entry_o.word = {data[31:24], 8'h80, 16'h0000};
        3'd2:    entry_o.word = {data[31:16], 8'h80, 8'h00};
        3'd3:    entry_o.word = {data[31:8], 8'h80};
        default: entry_o.word = data;
      endcase
    end
  end

endmodule

// ----- hdl/sha1_queue.sv -----
// ============================================================================
// SHA-1 word queue
// Small FIFO of classified words between the front end and the core.
// ============================================================================
module sha1_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sha1_pkg::q_entry_t entry_i,
  input  logic               pop_i,
  output logic               valid_o,
  output sha1_pkg::q_entry_t entry_o,
  output logic               full_o
);
  import sha1_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  q_entry_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/sha1_core.sv -----
// ============================================================================
// SHA-1 compression core
// Assembles blocks in a sliding message schedule, generates padding and the
// length words, runs one round per cycle and delivers the digest words.
// ============================================================================
module sha1_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  sha1_pkg::q_entry_t   q_entry_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sha1_pkg::word_t      out_word_o,
  output logic [2:0]           out_idx_o,
  output logic                 out_last_o,
  output sha1_pkg::core_stat_t stat_o
);
  import sha1_pkg::*;

  core_state_e state_q, state_d;
  logic [4:0]  fill_q;
  logic [6:0]  rnd_q;
  logic [63:0] len_q;
  logic        pad_q, mark_q, lenhi_q, final_q;
  logic [2:0]  emit_idx_q;
  word_t       chain_q [DigestWords];
  word_t       w_q [BlkWords];
  word_t       a_q, b_q, c_q, d_q, e_q;
  logic        out_valid_q, out_last_q;
  word_t       out_word_q;
  logic [2:0]  out_idx_q;

  logic  pop, pad_shift, shift_en, round_en, fold, emit_load, enter_round;
  word_t pad_word, shift_word, sched, temp, xw;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_FILL: begin
        if (q_valid_i) begin
          if (fill_q == 5'd15) begin
            state_d = ST_ROUND;
          end else if (q_entry_i.last) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (fill_q == 5'd15) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd_q == 7'(NumRounds - 1)) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (final_q) begin
          state_d = ST_EMIT;
        end else if (pad_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_FILL;
        end
      end
      ST_EMIT: begin
        if ((!out_valid_q || out_ready_i) && emit_idx_q == LastIdx) begin
          state_d = ST_FILL;
        end
      end
      default: state_d = ST_FILL;
    endcase
  end

  // Datapath strobes.
  always_comb begin
    pop       = (state_q == ST_FILL) && q_valid_i;
    pad_shift = (state_q == ST_PAD);
    round_en  = (state_q == ST_ROUND);
    fold      = (state_q == ST_FOLD);
    emit_load = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
    priority if (mark_q) begin
      pad_word = PadMarker;
    end else if (fill_q == 5'd14) begin
      pad_word = len_q[63:32];
    end else if (fill_q == 5'd15 && lenhi_q) begin
      pad_word = len_q[31:0];
    end else begin
      pad_word = '0;
    end
    shift_en    = pop || pad_shift;
    shift_word  = pop ? q_entry_i.word : pad_word;
    enter_round = (state_q != ST_ROUND) && (state_d == ST_ROUND);
  end

  assign q_pop_o = pop;

  // Round datapath.
  assign xw    = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
  assign sched = {xw[30:0], xw[31]};
  assign temp  = {a_q[26:0], a_q[31:27]} + round_f(rnd_q, b_q, c_q, d_q) + e_q
               + round_k(rnd_q) + w_q[0];

  always_ff @(posedge clk_i) begin
    if (shift_en || round_en) begin
      for (int i = 0; i < BlkWords - 1; i++) begin
        w_q[i] <= w_q[i + 1];
      end
      w_q[BlkWords - 1] <= round_en ? sched : shift_word;
    end
    if (enter_round) begin
      a_q <= chain_q[0];
      b_q <= chain_q[1];
      c_q <= chain_q[2];
      d_q <= chain_q[3];
      e_q <= chain_q[4];
    end else if (round_en) begin
      a_q <= temp;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end
    if (emit_load) begin
      out_word_q <= chain_q[emit_idx_q];
      out_idx_q  <= emit_idx_q;
      out_last_q <= (emit_idx_q == LastIdx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      fill_q      <= '0;
      rnd_q       <= '0;
      len_q       <= '0;
      pad_q       <= 1'b0;
      mark_q      <= 1'b0;
      lenhi_q     <= 1'b0;
      final_q     <= 1'b0;
      emit_idx_q  <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < DigestWords; i++) begin
        chain_q[i] <= InitH[i];
      end
    end else begin
      state_q <= state_d;
      if (shift_en) begin
        fill_q <= fill_q + 1'b1;
      end
      if (enter_round) begin
        rnd_q <= '0;
      end else if (round_en) begin
        rnd_q <= rnd_q + 1'b1;
      end
      if (pop) begin
        len_q <= len_q + {58'd0, q_entry_i.nbytes, 3'd0};
        if (q_entry_i.last) begin
          pad_q  <= 1'b1;
          mark_q <= q_entry_i.mark_next;
        end
      end
      if (pad_shift) begin
        if (mark_q) begin
          mark_q <= 1'b0;
        end else if (fill_q == 5'd14) begin
          lenhi_q <= 1'b1;
        end else if (fill_q == 5'd15 && lenhi_q) begin
          final_q <= 1'b1;
        end
      end
      if (fold) begin
        fill_q     <= '0;
        chain_q[0] <= chain_q[0] + a_q;
        chain_q[1] <= chain_q[1] + b_q;
        chain_q[2] <= chain_q[2] + c_q;
        chain_q[3] <= chain_q[3] + d_q;
        chain_q[4] <= chain_q[4] + e_q;
      end
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (emit_load) begin
        if (emit_idx_q == LastIdx) begin
          // Digest captured; start over for the next message.
          emit_idx_q <= '0;
          len_q      <= '0;
          pad_q      <= 1'b0;
          mark_q     <= 1'b0;
          lenhi_q    <= 1'b0;
          final_q    <= 1'b0;
          for (int i = 0; i < DigestWords; i++) begin
            chain_q[i] <= InitH[i];
          end
        end else begin
          emit_idx_q <= emit_idx_q + 1'b1;
        end
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_word_o   = out_word_q;
  assign out_idx_o    = out_idx_q;
  assign out_last_o   = out_last_q;
  assign stat_o.state = state_q;
  assign stat_o.fill  = fill_q;

endmodule

// ----- hdl/sha1_hash_engine.sv -----
// Each 64-byte block is filled word by word, then runs 80 rounds and a fold on
// the single shared round unit, and the core takes no words of a new block before the fold.
// With the core idle, the first digest beat follows the last message beat after
// the padding words and one or two compressions.
// Reset: asynchronous, active low; the chaining state returns to the initial
// values and the input queue empties. No clearing pass is needed.
// ============================================================================
// SHA-1 hash engine
// Streams a byte message in as big-endian 32-bit beats and streams the five
// digest words out after the beat marked last.
// ============================================================================
module sha1_hash_engine #(
  parameter int unsigned QueueDepth = 4  // words buffered ahead of the core, 2 to 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [31:0] data_word, [34:32] valid_bytes, rest zero
  input  logic        s_axis_tlast,   // last_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
  output logic        m_axis_tlast    // last_of_digest
);
  import sha1_pkg::*;

  // The front end masks and marks the last word and settles the length each
  // beat contributes; the queue lets it keep taking beats, until it is full,
  // while the core runs its rounds.
  logic       push, q_full, q_valid, q_pop;
  q_entry_t   push_entry, pop_entry;
  word_t      out_word;
  logic [2:0] out_idx;
  core_stat_t core_stat;

  sha1_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_full_i      (q_full),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  sha1_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (pop_entry),
    .full_o  (q_full)
  );

  // The core owns the block schedule, the round state and the output register,
  // so a stalled digest beat never blocks the queue from filling.
  sha1_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (pop_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_word_o  (out_word),
    .out_idx_o   (out_idx),
    .out_last_o  (m_axis_tlast),
    .stat_o      (core_stat)
  );

  assign m_axis_tdata = {5'd0, out_idx, out_word};

  // The block schedule never holds more than one block of words.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_stat.fill <= 5'd16)
    else $error("block fill count exceeds sixteen words");

  // Digest beats only follow a completed fold, which empties the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_stat.state == ST_EMIT |-> core_stat.fill == 5'd0)
    else $error("digest output started with a partial block");

  // The final digest beat carries the last word index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[34:32] == LastIdx)
    else $error("last digest beat with wrong word index");

  // A new digest cannot follow directly after the final beat of one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
    else $error("digest beat right after the end of a digest");

endmodule
